/* src/jhs_pkg.sv */
// ----------------------------------------------------------------------------
// jhs_pkg: shared constants and helpers of the Jacobi heat stencil
// Grid geometry, field widths, command codes, register indexes and the
// cell address mapping used by the channel interfaces and the core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package jhs_pkg;

  // Grid geometry
  localparam int GRID_MAX = 64;
  localparam int IDX_W    = $clog2(GRID_MAX);
  localparam int ADDR_W   = 2 * IDX_W;
  localparam int CELLS    = GRID_MAX * GRID_MAX;

  // Field widths
  localparam int TEMP_W    = 32;
  localparam int SUM_W     = TEMP_W + 2;
  localparam int POS_W     = 7;
  localparam int FUNC_W    = 2;
  localparam int LIMIT_W   = 16;
  localparam int CFG_IDX_W = 3;

  // Command codes
  localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_RUN   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GRID_SIZE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ITERATION_LIMIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DIFFERENCE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_LEFT       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_TOP        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_RIGHT      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_BOTTOM     = 3'd6;

  // Map a 1-based interior position to its bank address (row major)
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [POS_W-1:0] r,
                                                  input logic [POS_W-1:0] c);
    logic [POS_W-1:0] rm;
    logic [POS_W-1:0] cm;
    rm = r - POS_W'(1);
    cm = c - POS_W'(1);
    return {rm[IDX_W-1:0], cm[IDX_W-1:0]};
  endfunction

endpackage

`default_nettype wire

/* src/jhs_ifs.sv */
// ----------------------------------------------------------------------------
// jhs_ifs: valid/ready channels of the Jacobi heat stencil
// Command, result and configuration channels, each with a source and a
// sink modport. A transfer happens on a rising edge with valid and ready high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface jhs_cmd_if;
  import jhs_pkg::*;
  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [POS_W-1:0]    row;
  logic [POS_W-1:0]    col;
  logic [TEMP_W-1:0]   cell_value;
  modport source (output valid, func, row, col, cell_value, input ready);
  modport sink   (input valid, func, row, col, cell_value, output ready);
endinterface

interface jhs_res_if;
  import jhs_pkg::*;
  logic                valid;
  logic                ready;
  logic [TEMP_W-1:0]   read_value;
  logic [LIMIT_W-1:0]  sweeps_done;
  logic                converged;
  logic [TEMP_W-1:0]   final_change;
  modport source (output valid, read_value, sweeps_done, converged, final_change,
                  input ready);
  modport sink   (input valid, read_value, sweeps_done, converged, final_change,
                  output ready);
endinterface

interface jhs_cfg_if;
  import jhs_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [TEMP_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* src/jacobi_heat_stencil.sv */
// ----------------------------------------------------------------------------
// jacobi_heat_stencil: Jacobi heat-diffusion stencil on a fixed-edge grid
// Two ping-pong banks hold the interior in unsigned Q16.16. One shared
// accumulator gathers the four neighbours of each cell under a sequencer.
// ----------------------------------------------------------------------------
//  channel  dir  handshake    payload
//  cfg      in   valid/ready  index, data (always ready)
//  cmd      in   valid/ready  func, row, col, cell_value
//  res      out  valid/ready  read_value, sweeps_done, converged, final_change
//
//  Interior reads pass through the registered bank read; frame reads are
//  served from the edge registers. Each cell of a run costs five operand
//  fetches through the single read port, one drain and one write-back, and
//  each sweep ends with a merge and a check. After reset a clearing pass
//  zeroes both banks; cmd stays not ready meanwhile, cfg is served as ever.
//  A finished result waits in the output register while cmd is ready again.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module jacobi_heat_stencil (
  input  logic      clk,
  input  logic      rst,
  jhs_cfg_if.sink   cfg,
  jhs_cmd_if.sink   cmd,
  jhs_res_if.source res
);
  import jhs_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_READ, S_FETCH, S_DRAIN, S_WRITE, S_MERGE, S_CHECK, S_EMIT
  } state_t;

  typedef enum logic [2:0] {
    STEP_UP, STEP_DOWN, STEP_LEFT, STEP_RIGHT, STEP_CENTER
  } step_t;

  // Configuration registers
  logic [POS_W-1:0]   grid_size;
  logic [LIMIT_W-1:0] iteration_limit;
  logic [TEMP_W-1:0]  max_difference;
  logic [TEMP_W-1:0]  edge_left;
  logic [TEMP_W-1:0]  edge_top;
  logic [TEMP_W-1:0]  edge_right;
  logic [TEMP_W-1:0]  edge_bottom;

  // Control and status
  state_t             state;
  step_t              step;
  logic [ADDR_W-1:0]  clr_addr;
  logic               current_bank;
  logic [TEMP_W-1:0]  largest_change;
  logic [LIMIT_W-1:0] sweep_counter;
  logic               converged_flag;
  logic               p_valid;
  logic               diff_valid;
  logic               out_valid;

  // Datapath registers
  logic [POS_W-1:0]   r;
  logic [POS_W-1:0]   c;
  logic               p_center;
  logic               p_edge;
  logic [TEMP_W-1:0]  p_edge_val;
  logic [SUM_W-1:0]   acc;
  logic [TEMP_W-1:0]  old;
  logic [TEMP_W-1:0]  diff;
  logic [TEMP_W-1:0]  most;
  logic [TEMP_W-1:0]  res_read;
  logic [TEMP_W-1:0]  out_read;
  logic [LIMIT_W-1:0] out_sweeps;
  logic               out_conv;
  logic [TEMP_W-1:0]  out_change;

  // Banks
  logic [TEMP_W-1:0]  bank_a [CELLS];
  logic [TEMP_W-1:0]  bank_b [CELLS];
  logic [TEMP_W-1:0]  rd_a;
  logic [TEMP_W-1:0]  rd_b;
  logic               mem_we_a;
  logic               mem_we_b;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [TEMP_W-1:0]  mem_wdata;
  logic [ADDR_W-1:0]  mem_raddr;

  // Combinational helpers
  logic [POS_W-1:0]   n;
  logic [POS_W-1:0]   n_plus1;
  logic               cmd_fire;
  logic               cfg_fire;
  logic               wr_inside;
  logic               rd_in_range;
  logic [POS_W-1:0]   nb_row;
  logic [POS_W-1:0]   nb_col;
  logic               nb_edge;
  logic [TEMP_W-1:0]  nb_edge_val;
  logic [TEMP_W-1:0]  src_rd;
  logic [TEMP_W-1:0]  p_operand;
  logic [SUM_W-1:0]   acc_sum;
  logic [TEMP_W-1:0]  new_val;
  logic [TEMP_W-1:0]  diff_next;
  logic [LIMIT_W:0]   sweeps_next;

  assign cmd_fire  = cmd.valid && cmd.ready;
  assign cfg_fire  = cfg.valid && cfg.ready;
  assign cmd.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;

  assign res.valid        = out_valid;
  assign res.read_value   = out_read;
  assign res.sweeps_done  = out_sweeps;
  assign res.converged    = out_conv;
  assign res.final_change = out_change;

  // Clamp the grid size to 1..GRID_MAX
  always_comb begin
    if (grid_size == '0) begin
      n = POS_W'(1);
    end else if (grid_size > POS_W'(GRID_MAX)) begin
      n = POS_W'(GRID_MAX);
    end else begin
      n = grid_size;
    end
  end
  assign n_plus1 = n + POS_W'(1);

  assign wr_inside   = (cmd.row >= POS_W'(1)) && (cmd.row <= n) &&
                       (cmd.col >= POS_W'(1)) && (cmd.col <= n);
  assign rd_in_range = (cmd.row <= n_plus1) && (cmd.col <= n_plus1);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_size       <= POS_W'(GRID_MAX);
      iteration_limit <= LIMIT_W'(1);
      max_difference  <= '0;
      edge_left       <= '0;
      edge_top        <= '0;
      edge_right      <= '0;
      edge_bottom     <= '0;
    end else if (cfg_fire) begin
      case (cfg.index)
        REG_GRID_SIZE:       grid_size       <= cfg.data[POS_W-1:0];
        REG_ITERATION_LIMIT: iteration_limit <= cfg.data[LIMIT_W-1:0];
        REG_MAX_DIFFERENCE:  max_difference  <= cfg.data;
        REG_EDGE_LEFT:       edge_left       <= cfg.data;
        REG_EDGE_TOP:        edge_top        <= cfg.data;
        REG_EDGE_RIGHT:      edge_right      <= cfg.data;
        REG_EDGE_BOTTOM:     edge_bottom     <= cfg.data;
        default: ;
      endcase
    end
  end

  // Pick the neighbour of the current cell for this step
  always_comb begin
    nb_row      = r;
    nb_col      = c;
    nb_edge     = 1'b0;
    nb_edge_val = '0;
    case (step)
      STEP_UP: begin
        nb_row      = r - POS_W'(1);
        nb_edge     = (r == POS_W'(1));
        nb_edge_val = edge_top;
      end
      STEP_DOWN: begin
        nb_row      = r + POS_W'(1);
        nb_edge     = (r == n);
        nb_edge_val = edge_bottom;
      end
      STEP_LEFT: begin
        nb_col      = c - POS_W'(1);
        nb_edge     = (c == POS_W'(1));
        nb_edge_val = edge_left;
      end
      STEP_RIGHT: begin
        nb_col      = c + POS_W'(1);
        nb_edge     = (c == n);
        nb_edge_val = edge_right;
      end
      default: ;
    endcase
  end

  // Shared accumulator and change unit
  assign src_rd    = current_bank ? rd_b : rd_a;
  assign p_operand = p_edge ? p_edge_val : src_rd;
  assign acc_sum   = acc + {2'b00, p_operand};
  assign new_val   = acc[SUM_W-1:2];
  assign diff_next = (new_val > old) ? (new_val - old) : (old - new_val);
  assign sweeps_next = {1'b0, sweep_counter} + (LIMIT_W+1)'(1);

  // Bank address and write selection
  assign mem_raddr = (state == S_IDLE) ? cell_addr(cmd.row, cmd.col)
                                       : cell_addr(nb_row, nb_col);

  always_comb begin
    mem_we_a  = 1'b0;
    mem_we_b  = 1'b0;
    mem_waddr = cell_addr(cmd.row, cmd.col);
    mem_wdata = cmd.cell_value;
    case (state)
      S_CLEAR: begin
        mem_we_a  = 1'b1;
        mem_we_b  = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
      end
      S_IDLE: begin
        if (cmd_fire && (cmd.func == FUNC_WRITE) && wr_inside) begin
          mem_we_a = 1'b1;
          mem_we_b = 1'b1;
        end
      end
      S_WRITE: begin
        mem_waddr = cell_addr(r, c);
        mem_wdata = new_val;
        mem_we_a  = current_bank;
        mem_we_b  = !current_bank;
      end
      default: ;
    endcase
  end

  // Bank A
  always_ff @(posedge clk) begin
    if (mem_we_a) begin
      bank_a[mem_waddr] <= mem_wdata;
    end
    rd_a <= bank_a[mem_raddr];
  end

  // Bank B
  always_ff @(posedge clk) begin
    if (mem_we_b) begin
      bank_b[mem_waddr] <= mem_wdata;
    end
    rd_b <= bank_b[mem_raddr];
  end

  // Sequencer, datapath and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CLEAR;
      step           <= STEP_UP;
      clr_addr       <= '0;
      current_bank   <= 1'b0;
      largest_change <= '0;
      sweep_counter  <= '0;
      converged_flag <= 1'b0;
      p_valid        <= 1'b0;
      diff_valid     <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      // Drop the result once transferred, unless a new one is loaded now
      if (res.ready && (state != S_EMIT)) begin
        out_valid <= 1'b0;
      end

      // Retire the operand read in the previous cycle
      if (p_valid) begin
        if (p_center) begin
          old <= p_operand;
        end else begin
          acc <= acc_sum;
        end
      end

      // Fold the last cell change into the sweep maximum
      if (diff_valid) begin
        if (diff > most) begin
          most <= diff;
        end
        diff_valid <= 1'b0;
      end

      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == ADDR_W'(CELLS - 1)) begin
            state <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (cmd_fire) begin
            res_read <= '0;
            state    <= S_EMIT;
            case (cmd.func)
              FUNC_RUN: begin
                sweep_counter  <= '0;
                converged_flag <= 1'b0;
                largest_change <= '0;
                most           <= '0;
                acc            <= '0;
                r              <= POS_W'(1);
                c              <= POS_W'(1);
                step           <= STEP_UP;
                p_valid        <= 1'b0;
                diff_valid     <= 1'b0;
                if (iteration_limit != '0) begin
                  state <= S_FETCH;
                end
              end
              FUNC_READ: begin
                if (rd_in_range) begin
                  if (cmd.col == '0) begin
                    res_read <= edge_left;
                  end else if (cmd.col == n_plus1) begin
                    res_read <= edge_right;
                  end else if (cmd.row == '0) begin
                    res_read <= edge_top;
                  end else if (cmd.row == n_plus1) begin
                    res_read <= edge_bottom;
                  end else begin
                    state <= S_READ;
                  end
                end
              end
              default: ;
            endcase
          end
        end

        S_READ: begin
          res_read <= src_rd;
          state    <= S_EMIT;
        end

        // Issue one neighbour or center read per cycle
        S_FETCH: begin
          p_valid    <= 1'b1;
          p_center   <= (step == STEP_CENTER);
          p_edge     <= nb_edge;
          p_edge_val <= nb_edge_val;
          if (step == STEP_CENTER) begin
            step  <= STEP_UP;
            state <= S_DRAIN;
          end else begin
            step <= step_t'(step + 3'd1);
          end
        end

        S_DRAIN: begin
          p_valid <= 1'b0;
          state   <= S_WRITE;
        end

        // Write the new cell and advance the raster position
        S_WRITE: begin
          diff       <= diff_next;
          diff_valid <= 1'b1;
          acc        <= '0;
          state      <= S_FETCH;
          if (c == n) begin
            c <= POS_W'(1);
            if (r == n) begin
              state <= S_MERGE;
            end else begin
              r <= r + POS_W'(1);
            end
          end else begin
            c <= c + POS_W'(1);
          end
        end

        S_MERGE: begin
          state <= S_CHECK;
        end

        // Close the sweep and decide whether to go on
        S_CHECK: begin
          largest_change <= most;
          sweep_counter  <= sweeps_next[LIMIT_W-1:0];
          current_bank   <= !current_bank;
          if (most < max_difference) begin
            converged_flag <= 1'b1;
            state          <= S_EMIT;
          end else if (sweeps_next >= {1'b0, iteration_limit}) begin
            state <= S_EMIT;
          end else begin
            most  <= '0;
            r     <= POS_W'(1);
            c     <= POS_W'(1);
            state <= S_FETCH;
          end
        end

        // Hand the result to the output register when it is free
        S_EMIT: begin
          if (!out_valid || res.ready) begin
            out_valid  <= 1'b1;
            out_read   <= res_read;
            out_sweeps <= sweep_counter;
            out_conv   <= converged_flag;
            out_change <= largest_change;
            state      <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // Reset always restarts the clearing pass
  a_reset_clears: assert property (@(posedge clk)
    rst |=> (state == S_CLEAR) && (clr_addr == '0))
    else $error("reset did not restart the clearing pass");

  // The operand pipeline is empty when a cell is written back
  a_drained_at_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_WRITE) |-> !p_valid)
    else $error("operand still in flight at cell write-back");

  // The last cell change is folded in before the sweep closes
  a_merged_at_check: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK) |-> !diff_valid)
    else $error("sweep closed before last change was merged");

  // Each closed sweep flips the source bank
  a_bank_flip: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK) |=> (current_bank != $past(current_bank)))
    else $error("bank did not flip after a sweep");

  // Raster position stays inside the largest interior (1..GRID_MAX)
  a_position_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_FETCH) |-> (r >= POS_W'(1)) && (c >= POS_W'(1)) &&
                           (r <= POS_W'(GRID_MAX)) && (c <= POS_W'(GRID_MAX)))
    else $error("sweep position outside the interior");

endmodule

`default_nettype wire

/* tb/jhs_result_check.sv */
// ----------------------------------------------------------------------------
// jhs_result_check: result predictor and comparator for the heat stencil
// Watches the configuration, command and result channels. Keeps its own copy
// of the two grid banks, the edge registers and the run status, predicts one
// result per accepted command and compares each result transfer, field by
// field, with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jhs_result_check (
  input  logic      clk,
  input  logic      rst,
  jhs_cfg_if        cfg,
  jhs_cmd_if        cmd,
  jhs_res_if        res,
  output int        mismatches,
  output int        results_seen,
  output int        backlog,
  output int        threshold_stops
);
  import jhs_pkg::*;

  typedef logic [TEMP_W-1:0] temp_t;

  typedef struct packed {
    temp_t              read_value;
    logic [LIMIT_W-1:0] sweeps_done;
    logic               converged;
    temp_t              final_change;
  } outcome_t;

  // Predicted grid: two banks, the live one holds the current temperatures
  temp_t              plane [2][CELLS];
  logic               live;
  temp_t              last_change;
  logic [LIMIT_W-1:0] sweeps;
  logic               settled;

  // Register copies
  logic [POS_W-1:0]   n_reg;
  logic [LIMIT_W-1:0] limit_reg;
  temp_t              stop_below;
  temp_t              left_t, top_t, right_t, bottom_t;

  outcome_t           due_results [$];
  int                 errs, seen, stops;

  // Active interior size: zero behaves as one, oversize clamps to the maximum
  function automatic int span();
    if (n_reg == 0) return 1;
    if (n_reg > GRID_MAX) return GRID_MAX;
    return int'(n_reg);
  endfunction

  function automatic int slot(input int r, input int c);
    return (r - 1) * GRID_MAX + (c - 1);
  endfunction

  // Column edges win over row edges at the corners
  function automatic temp_t temp_at(input logic b, input int r, input int c, input int n);
    if (c == 0) return left_t;
    if (c == n + 1) return right_t;
    if (r == 0) return top_t;
    if (r == n + 1) return bottom_t;
    return plane[b][slot(r, c)];
  endfunction

  // Quarter of the exact four-neighbour sum, truncated
  function automatic temp_t mean4(input temp_t a, input temp_t b, input temp_t c,
                                  input temp_t d);
    logic [SUM_W-1:0] s;
    s = SUM_W'(a) + SUM_W'(b) + SUM_W'(c) + SUM_W'(d);
    return temp_t'(s >> 2);
  endfunction

  // One Jacobi sweep from the live bank into the other, then swap
  task automatic relax(input int n);
    logic  src, dst;
    temp_t worst, prev, fresh, delta;
    src   = live;
    dst   = ~live;
    worst = '0;
    for (int r = 1; r <= n; r++) begin
      for (int c = 1; c <= n; c++) begin
        prev  = plane[src][slot(r, c)];
        fresh = mean4(temp_at(src, r - 1, c, n), temp_at(src, r + 1, c, n),
                      temp_at(src, r, c - 1, n), temp_at(src, r, c + 1, n));
        delta = (fresh > prev) ? fresh - prev : prev - fresh;
        if (delta > worst) worst = delta;
        plane[dst][slot(r, c)] = fresh;
      end
    end
    live        = dst;
    last_change = worst;
  endtask

  // Sweep until the limit, or stop on the first sweep below the threshold
  task automatic run_sweeps();
    int n;
    int k;
    n           = span();
    k           = 0;
    sweeps      = '0;
    settled     = 1'b0;
    last_change = '0;
    while (k < int'(limit_reg) && !settled) begin
      relax(n);
      sweeps++;
      k++;
      if (last_change < stop_below) settled = 1'b1;
    end
    if (settled) stops++;
  endtask

  task automatic clear_state();
    for (int i = 0; i < CELLS; i++) begin
      plane[0][i] = '0;
      plane[1][i] = '0;
    end
    live        = 1'b0;
    last_change = '0;
    sweeps      = '0;
    settled     = 1'b0;
    n_reg       = POS_W'(GRID_MAX);
    limit_reg   = LIMIT_W'(1);
    stop_below  = '0;
    left_t      = '0;
    top_t       = '0;
    right_t     = '0;
    bottom_t    = '0;
    due_results.delete();
    errs        = 0;
    seen        = 0;
    stops       = 0;
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input temp_t data);
    case (idx)
      REG_GRID_SIZE:       n_reg      = data[POS_W-1:0];
      REG_ITERATION_LIMIT: limit_reg  = data[LIMIT_W-1:0];
      REG_MAX_DIFFERENCE:  stop_below = data;
      REG_EDGE_LEFT:       left_t     = data;
      REG_EDGE_TOP:        top_t      = data;
      REG_EDGE_RIGHT:      right_t    = data;
      REG_EDGE_BOTTOM:     bottom_t   = data;
      default: ;
    endcase
  endtask

  // Compare a result transfer with the oldest prediction
  task automatic compare_result();
    outcome_t want;
    if (due_results.size() == 0) begin
      $error("result transfer with no command waiting");
      errs++;
    end else begin
      want = due_results.pop_front();
      if (res.read_value !== want.read_value) begin
        $error("read_value: expected %h, got %h", want.read_value, res.read_value);
        errs++;
      end
      if (res.sweeps_done !== want.sweeps_done) begin
        $error("sweeps_done: expected %0d, got %0d", want.sweeps_done, res.sweeps_done);
        errs++;
      end
      if (res.converged !== want.converged) begin
        $error("converged: expected %b, got %b", want.converged, res.converged);
        errs++;
      end
      if (res.final_change !== want.final_change) begin
        $error("final_change: expected %h, got %h", want.final_change, res.final_change);
        errs++;
      end
    end
    seen++;
  endtask

  // Apply a command transfer to the predicted grid and queue its result
  task automatic predict_command();
    outcome_t want;
    int       r, c, n;
    r    = int'(cmd.row);
    c    = int'(cmd.col);
    n    = span();
    want = '0;
    case (cmd.func)
      FUNC_WRITE: begin
        if (r >= 1 && r <= n && c >= 1 && c <= n) begin
          plane[0][slot(r, c)] = cmd.cell_value;
          plane[1][slot(r, c)] = cmd.cell_value;
        end
      end
      FUNC_RUN: run_sweeps();
      FUNC_READ: begin
        if (r <= n + 1 && c <= n + 1) want.read_value = temp_at(live, r, c, n);
      end
      default: ;
    endcase
    want.sweeps_done  = sweeps;
    want.converged    = settled;
    want.final_change = last_change;
    due_results.push_back(want);
  endtask

  // Sample every channel on the rising edge
  always @(posedge clk) begin
    if (rst) begin
      clear_state();
    end else begin
      if (cfg.valid && cfg.ready) set_reg(cfg.index, cfg.data);
      if (res.valid && res.ready) compare_result();
      if (cmd.valid && cmd.ready) predict_command();
    end
    mismatches      <= errs;
    results_seen    <= seen;
    backlog         <= due_results.size();
    threshold_stops <= stops;
  end

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the Jacobi heat stencil
// Drives directed corner cases, then random phases: each phase sets all
// registers, loads the interior, runs sweeps and probes cells and frame,
// with stray commands mixed in. Both channels stall at random. Checking is
// done by the result checker placed beside the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import jhs_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int    RANDOM_ITEMS = 1400;
  localparam int    CYCLE_LIMIT  = 10_000_000;
  localparam int    TAIL_CYCLES  = 40;

  logic clk;
  logic rst;
  logic steady;
  int   cycles;
  int   sent, writes, runs, reads, unused, phases, size_now;
  int   mismatches, results_seen, backlog, threshold_stops;

  jhs_cfg_if cfg ();
  jhs_cmd_if cmd ();
  jhs_res_if res ();

  jacobi_heat_stencil dut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg),
    .cmd (cmd),
    .res (res)
  );

  jhs_result_check u_check (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .cmd             (cmd),
    .res             (res),
    .mismatches      (mismatches),
    .results_seen    (results_seen),
    .backlog         (backlog),
    .threshold_stops (threshold_stops)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Result side: stall about a third of the cycles unless in a steady stretch
  initial begin
    res.ready = 1'b0;
    forever begin
      @(posedge clk);
      res.ready <= !rst && (steady || $urandom_range(0, 99) >= 33);
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic [TEMP_W-1:0] rand_temp();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return $urandom();
    endcase
  endfunction

  // Drive one command and hold it until the transfer
  task automatic issue(input logic [FUNC_W-1:0] f, input int r, input int c,
                       input logic [TEMP_W-1:0] v);
    if (!steady && $urandom_range(0, 99) < 33) begin
      cmd.valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    cmd.valid      <= 1'b1;
    cmd.func       <= f;
    cmd.row        <= POS_W'(r);
    cmd.col        <= POS_W'(c);
    cmd.cell_value <= v;
    @(posedge clk);
    while (!cmd.ready) @(posedge clk);
    sent++;
    case (f)
      FUNC_WRITE: writes++;
      FUNC_RUN:   runs++;
      FUNC_READ:  reads++;
      default:    unused++;
    endcase
  endtask

  // Drop valid and wait until every result has come back
  task automatic drain();
    cmd.valid <= 1'b0;
    @(posedge clk);
    while (results_seen != sent) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TEMP_W-1:0] data);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= data;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
  endtask

  // Write every register while the block is idle
  task automatic configure(input int gs, input int lim, input logic [TEMP_W-1:0] thr,
                           input logic [TEMP_W-1:0] l, input logic [TEMP_W-1:0] t,
                           input logic [TEMP_W-1:0] r, input logic [TEMP_W-1:0] b);
    logic [TEMP_W-1:0] gs_word, lim_word;
    drain();
    // Upper bits beyond the register width are sometimes set to show they drop
    gs_word  = $urandom();
    lim_word = $urandom();
    if ($urandom_range(0, 3) != 0) begin
      gs_word  = '0;
      lim_word = '0;
    end
    gs_word[POS_W-1:0]    = POS_W'(gs);
    lim_word[LIMIT_W-1:0] = LIMIT_W'(lim);
    write_reg(REG_GRID_SIZE, gs_word);
    write_reg(REG_ITERATION_LIMIT, lim_word);
    write_reg(REG_MAX_DIFFERENCE, thr);
    write_reg(REG_EDGE_LEFT, l);
    write_reg(REG_EDGE_TOP, t);
    write_reg(REG_EDGE_RIGHT, r);
    write_reg(REG_EDGE_BOTTOM, b);
    cfg.valid <= 1'b0;
    size_now = (gs == 0) ? 1 : (gs > GRID_MAX) ? GRID_MAX : gs;
    phases++;
  endtask

  initial begin
    int                useful, phase, gs, lim, n, rounds, probes, r, c;
    logic [TEMP_W-1:0] thr;

    rst            = 1'b1;
    steady         = 1'b0;
    cycles         = 0;
    sent           = 0;
    writes         = 0;
    runs           = 0;
    reads          = 0;
    unused         = 0;
    phases         = 0;
    size_now       = GRID_MAX;
    cmd.valid      = 1'b0;
    cmd.func       = FUNC_WRITE;
    cmd.row        = '0;
    cmd.col        = '0;
    cmd.cell_value = '0;
    cfg.valid      = 1'b0;
    cfg.index      = REG_GRID_SIZE;
    cfg.data       = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: full grid, one sweep, zero threshold never stops a run
    issue(FUNC_WRITE, 1, 1, 32'hFFFF_FFFF);
    issue(FUNC_WRITE, GRID_MAX, GRID_MAX, 32'h0001_0000);
    issue(FUNC_WRITE, 0, 5, 32'h1234_5678);
    issue(FUNC_WRITE, GRID_MAX + 1, 1, 32'h8765_4321);
    issue(FUNC_UNUSED, 1, 1, 32'hDEAD_BEEF);
    issue(FUNC_READ, 1, 1, '0);
    issue(FUNC_READ, GRID_MAX, GRID_MAX, '0);
    issue(FUNC_RUN, 0, 0, '0);
    issue(FUNC_READ, 1, 2, '0);
    issue(FUNC_READ, GRID_MAX + 2, 1, '0);

    // Grid size zero acts as one; zero iteration limit does no sweep
    configure(0, 0, '0, 32'hFFFF_FFFF, '0, 32'hFFFF_FFFF, '0);
    issue(FUNC_RUN, 0, 0, '0);
    issue(FUNC_READ, 0, 0, '0);
    issue(FUNC_READ, 2, 2, '0);
    issue(FUNC_READ, 0, 1, '0);
    issue(FUNC_READ, 2, 1, '0);
    issue(FUNC_READ, 1, 1, '0);
    issue(FUNC_READ, 127, 127, '0);

    // Oversize grid clamps; widest threshold stops after the first sweep
    configure(127, 65535, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h1, '0);
    issue(FUNC_RUN, 0, 0, '0);
    issue(FUNC_READ, GRID_MAX + 1, GRID_MAX + 1, '0);
    issue(FUNC_READ, 32, GRID_MAX + 1, '0);
    issue(FUNC_READ, 10, 10, '0);

    // Random phases: load, run, probe, with stray commands mixed in
    useful = 0;
    phase  = 0;
    while (useful < RANDOM_ITEMS) begin
      phase++;
      steady = (phase >= 4 && phase < 9);
      case ($urandom_range(0, 15))
        0:       gs = 0;
        1:       gs = $urandom_range(7, 10);
        default: gs = $urandom_range(1, 5);
      endcase
      case ($urandom_range(0, 9))
        0: begin
          lim = 0;
          thr = rand_temp();
        end
        1, 2: begin
          // Long limits rely on the threshold, so keep the grid tiny
          lim = $urandom_range(50, 65535);
          thr = $urandom_range(32'h0001_0000, 32'h0100_0000);
          gs  = $urandom_range(1, 3);
        end
        3: begin
          lim = $urandom_range(1, 12);
          thr = '0;
        end
        4: begin
          lim = $urandom_range(1, 12);
          thr = $urandom();
        end
        default: begin
          lim = $urandom_range(1, 12);
          thr = $urandom_range(0, 32'h0010_0000);
        end
      endcase
      configure(gs, lim, thr, rand_temp(), rand_temp(), rand_temp(), rand_temp());
      n = size_now;

      // Load most of the interior
      for (int i = 1; i <= n; i++) begin
        for (int j = 1; j <= n; j++) begin
          if ($urandom_range(0, 7) != 0) begin
            issue(FUNC_WRITE, i, j, rand_temp());
            useful++;
          end
        end
      end

      rounds = $urandom_range(1, 3);
      repeat (rounds) begin
        issue(FUNC_RUN, $urandom_range(0, 127), $urandom_range(0, 127), $urandom());
        useful++;
        probes = $urandom_range(3, 8);
        repeat (probes) begin
          if ($urandom_range(0, 3) == 0) begin
            r = $urandom_range(0, 127);
            c = $urandom_range(0, 127);
          end else begin
            r = $urandom_range(0, n + 1);
            c = $urandom_range(0, n + 1);
          end
          if ($urandom_range(0, 4) == 0)
            issue(FUNC_WRITE, $urandom_range(1, n), $urandom_range(1, n), rand_temp());
          else
            issue(FUNC_READ, r, c, '0);
          useful++;
        end
        // Stray command with any code and any position
        if ($urandom_range(0, 3) == 0)
          issue(FUNC_W'($urandom_range(0, 3)), $urandom_range(0, 127),
                $urandom_range(0, 127), $urandom());
      end
    end
    steady = 1'b0;

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d commands: %0d writes, %0d runs, %0d reads, %0d unused codes",
             sent, writes, runs, reads, unused);
    $display("Register settings: %0d; results checked: %0d; runs stopped on threshold: %0d",
             phases, results_seen, threshold_stops);
    if (mismatches == 0 && backlog == 0 && results_seen == sent)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

/* sim.f */
src/jhs_pkg.sv
src/jhs_ifs.sv
src/jacobi_heat_stencil.sv
tb/jhs_result_check.sv
tb/testbench.sv
